/* src/kcl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package kcl_pkg;

  // default number of code digits
  localparam int CODE_DIGITS_DEF = 4;

  // register reset values
  localparam logic [15:0] PASSCODE_RST   = 16'h7890;
  localparam logic [15:0] OPEN_TICKS_RST = 16'd3000;
  localparam logic [15:0] ALARM_HALF_RST = 16'd200;
  localparam logic [3:0]  ALARM_PULS_RST = 4'd5;

  // input kinds
  localparam logic [1:0] KIND_KEY    = 2'd0;
  localparam logic [1:0] KIND_TICK   = 2'd1;
  localparam logic [1:0] KIND_REMOTE = 2'd2;

  // key codes
  localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
  localparam logic [3:0] KEY_STAR      = 4'd10;
  localparam logic [3:0] KEY_HASH      = 4'd11;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_GRANT  = 3'd1,
    EV_DENY   = 3'd2,
    EV_CLEAR  = 3'd3,
    EV_DIGIT  = 3'd4,
    EV_RELOCK = 3'd5
  } kcl_ev_t;

  typedef enum logic [1:0] {
    CFG_PASSCODE   = 2'd0,
    CFG_OPEN_TICKS = 2'd1,
    CFG_ALARM_HALF = 2'd2,
    CFG_ALARM_PULS = 2'd3
  } kcl_cfg_idx_t;

  typedef struct packed {
    logic [15:0] passcode;
    logic [15:0] open_ticks;
    logic [15:0] alarm_half_ticks;
    logic [3:0]  alarm_pulses;
  } kcl_cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] key_code;
    logic       remote_grant;
  } kcl_item_t;

  typedef struct packed {
    kcl_ev_t     event_res;
    logic        door_open;
    logic        alarm_on;
    logic [15:0] entered_code;
    logic [2:0]  entered_count;
  } kcl_res_t;

endpackage

`default_nettype wire

/* src/keypad_code_lock.sv */
`timescale 1ns / 1ps
`default_nettype none

// keypad door code lock
// item channel (item_valid / item_stall): one event per transfer, a key press,
//   a millisecond tick or a remote grant/deny decision
// result channel (res_valid / res_stall): exactly one result per item, in order,
//   carrying the event code, the relay drives and, on a hash check, the entry
// config channel (cfg_valid / cfg_ready): cfg_index picks passcode, open_ticks,
//   alarm_half_ticks or alarm_pulses; cfg_ready is always high, write only
//   while the block is idle
// path: the item sits in the input register while the combinational state
//   update feeds the result register
// throughput: one item per cycle while item_stall is low, via the state update
// stall: the input register keeps taking an item while the output register
//   holds a stalled result; only when both are full is item_stall raised
// reset: entry cleared, door locked, alarm off, registers to their defaults,
//   both pipeline registers empty

module keypad_code_lock #(
  parameter int CODE_DIGITS = kcl_pkg::CODE_DIGITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // item channel
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic [1:0]  kind,
  input  wire logic [3:0]  key_code,
  input  wire logic        remote_grant,
  // result channel
  output logic             res_valid,
  input  wire logic        res_stall,
  output logic [2:0]       event_res,
  output logic             door_open,
  output logic             alarm_on,
  output logic [15:0]      entered_code,
  output logic [2:0]       entered_count,
  // config channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  kcl_pkg::kcl_cfg_t  cfg;
  kcl_pkg::kcl_item_t item_q;
  kcl_pkg::kcl_res_t  res_comb;
  kcl_pkg::kcl_res_t  res_q;

  logic item_full;
  logic out_free;
  logic advance;

  // output register can take a result when empty or draining this cycle
  assign out_free   = !res_valid || !res_stall;
  assign advance    = item_full && out_free;
  assign item_stall = item_full && !out_free;
  assign cfg_ready  = 1'b1;

  kcl_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
    end else if (!item_stall) begin
      item_full <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      item_q.kind         <= kind;
      item_q.key_code     <= key_code;
      item_q.remote_grant <= remote_grant;
    end
  end

  // lock state and its combinational update
  kcl_ctrl #(
    .CODE_DIGITS (CODE_DIGITS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .step_en (advance),
    .item    (item_q),
    .cfg     (cfg),
    .res     (res_comb)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res_comb;
    end
  end

  assign event_res     = res_q.event_res;
  assign door_open     = res_q.door_open;
  assign alarm_on      = res_q.alarm_on;
  assign entered_code  = res_q.entered_code;
  assign entered_count = res_q.entered_count;

endmodule

`default_nettype wire

/* src/kcl_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none

module kcl_cfg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr_en,
  input  wire logic [1:0]        wr_index,
  input  wire logic [15:0]       wr_data,
  output kcl_pkg::kcl_cfg_t      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.passcode         <= kcl_pkg::PASSCODE_RST;
      cfg.open_ticks       <= kcl_pkg::OPEN_TICKS_RST;
      cfg.alarm_half_ticks <= kcl_pkg::ALARM_HALF_RST;
      cfg.alarm_pulses     <= kcl_pkg::ALARM_PULS_RST;
    end else if (wr_en) begin
      case (kcl_pkg::kcl_cfg_idx_t'(wr_index))
        kcl_pkg::CFG_PASSCODE:   cfg.passcode         <= wr_data;
        kcl_pkg::CFG_OPEN_TICKS: cfg.open_ticks       <= wr_data;
        kcl_pkg::CFG_ALARM_HALF: cfg.alarm_half_ticks <= wr_data;
        kcl_pkg::CFG_ALARM_PULS: cfg.alarm_pulses     <= wr_data[3:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* src/kcl_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module kcl_ctrl #(
  parameter int CODE_DIGITS = kcl_pkg::CODE_DIGITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step_en,
  input  kcl_pkg::kcl_item_t     item,
  input  kcl_pkg::kcl_cfg_t      cfg,
  output kcl_pkg::kcl_res_t      res
);

  localparam int DW = CODE_DIGITS * 4;
  localparam int EW = (DW > 16) ? DW : 16;
  localparam int CW = $clog2(CODE_DIGITS + 2);
  localparam int XW = (CW > 3) ? CW : 3;

  logic [DW-1:0] entry_digits, entry_digits_next;
  logic [CW-1:0] entry_count, entry_count_next;
  logic [15:0]   relock_countdown, relock_countdown_next;
  logic          door_unlocked, door_unlocked_next;
  logic [4:0]    alarm_phases_left, alarm_phases_left_next;
  logic [15:0]   alarm_phase_timer, alarm_phase_timer_next;

  logic [EW-1:0] entry_ext;
  logic [XW-1:0] count_ext;
  logic          code_match;
  logic          alarm_active;

  assign entry_ext    = EW'(entry_digits);
  assign count_ext    = XW'(entry_count);
  assign alarm_active = (alarm_phases_left != 5'd0);
  assign code_match   = (entry_count == CW'(CODE_DIGITS)) &&
                        (entry_ext == EW'(cfg.passcode));

  always_comb begin
    entry_digits_next      = entry_digits;
    entry_count_next       = entry_count;
    relock_countdown_next  = relock_countdown;
    door_unlocked_next     = door_unlocked;
    alarm_phases_left_next = alarm_phases_left;
    alarm_phase_timer_next = alarm_phase_timer;
    res.event_res          = kcl_pkg::EV_NONE;
    res.entered_code       = 16'd0;
    res.entered_count      = 3'd0;

    case (item.kind)
      kcl_pkg::KIND_KEY: begin
        if (!alarm_active) begin
          if (item.key_code <= kcl_pkg::KEY_DIGIT_MAX) begin
            entry_digits_next = (entry_digits << 4) | DW'(item.key_code);
            if (entry_count != CW'(CODE_DIGITS + 1)) begin
              entry_count_next = entry_count + CW'(1);
            end
            res.event_res = kcl_pkg::EV_DIGIT;
          end else if (item.key_code == kcl_pkg::KEY_STAR) begin
            entry_digits_next = '0;
            entry_count_next  = '0;
            res.event_res     = kcl_pkg::EV_CLEAR;
          end else if (item.key_code == kcl_pkg::KEY_HASH) begin
            res.entered_code  = entry_ext[15:0];
            res.entered_count = (count_ext > XW'(7)) ? 3'd7 : count_ext[2:0];
            if (code_match) begin
              door_unlocked_next    = 1'b1;
              relock_countdown_next = cfg.open_ticks;
              res.event_res         = kcl_pkg::EV_GRANT;
            end else begin
              alarm_phases_left_next = {cfg.alarm_pulses, 1'b0};
              alarm_phase_timer_next = cfg.alarm_half_ticks;
              res.event_res          = kcl_pkg::EV_DENY;
            end
            entry_digits_next = '0;
            entry_count_next  = '0;
          end
        end
      end
      kcl_pkg::KIND_TICK: begin
        if (door_unlocked) begin
          if (relock_countdown <= 16'd1) begin
            relock_countdown_next = 16'd0;
            door_unlocked_next    = 1'b0;
            res.event_res         = kcl_pkg::EV_RELOCK;
          end else begin
            relock_countdown_next = relock_countdown - 16'd1;
          end
        end
        if (alarm_active) begin
          if (alarm_phase_timer <= 16'd1) begin
            alarm_phases_left_next = alarm_phases_left - 5'd1;
            alarm_phase_timer_next = cfg.alarm_half_ticks;
          end else begin
            alarm_phase_timer_next = alarm_phase_timer - 16'd1;
          end
        end
      end
      kcl_pkg::KIND_REMOTE: begin
        if (item.remote_grant) begin
          door_unlocked_next    = 1'b1;
          relock_countdown_next = cfg.open_ticks;
          res.event_res         = kcl_pkg::EV_GRANT;
        end else begin
          alarm_phases_left_next = {cfg.alarm_pulses, 1'b0};
          alarm_phase_timer_next = cfg.alarm_half_ticks;
          res.event_res          = kcl_pkg::EV_DENY;
        end
      end
      default: ;
    endcase

    // relay drives follow the state after this step
    res.door_open = door_unlocked_next;
    res.alarm_on  = (alarm_phases_left_next != 5'd0) && !alarm_phases_left_next[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_digits      <= '0;
      entry_count       <= '0;
      relock_countdown  <= 16'd0;
      door_unlocked     <= 1'b0;
      alarm_phases_left <= 5'd0;
      alarm_phase_timer <= 16'd0;
    end else if (step_en) begin
      entry_digits      <= entry_digits_next;
      entry_count       <= entry_count_next;
      relock_countdown  <= relock_countdown_next;
      door_unlocked     <= door_unlocked_next;
      alarm_phases_left <= alarm_phases_left_next;
      alarm_phase_timer <= alarm_phase_timer_next;
    end
  end

endmodule

`default_nettype wire

/* src/kcl_chk.sv */
`timescale 1ns / 1ps
`default_nettype none

module kcl_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        res_valid,
  input wire logic        res_stall,
  input wire logic [2:0]  event_res,
  input wire logic        door_open,
  input wire logic [15:0] entered_code,
  input wire logic [2:0]  entered_count
);

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(event_res) && $stable(door_open))
    else $error("stalled result changed");

  // nothing comes out the cycle after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // entry report only on a grant or deny
  a_entry_report: assert property (@(posedge clk) disable iff (rst)
    res_valid && event_res != kcl_pkg::EV_GRANT && event_res != kcl_pkg::EV_DENY
      |-> entered_code == 16'd0 && entered_count == 3'd0)
    else $error("entry reported outside a check");

  // relay drive agrees with grant and relock events
  a_door_event: assert property (@(posedge clk) disable iff (rst)
    res_valid && (event_res == kcl_pkg::EV_GRANT || event_res == kcl_pkg::EV_RELOCK)
      |-> door_open == (event_res == kcl_pkg::EV_GRANT))
    else $error("door drive disagrees with event");

endmodule

bind keypad_code_lock kcl_chk u_kcl_chk (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (res_valid),
  .res_stall     (res_stall),
  .event_res     (event_res),
  .door_open     (door_open),
  .entered_code  (entered_code),
  .entered_count (entered_count)
);

`default_nettype wire

/* verif/keypad_code_lock_test.sv */
`timescale 1ns / 1ps

// self-checking bench for the keypad code lock
module keypad_code_lock_test;

  // kind code the block must ignore
  localparam logic [1:0] KIND_SPARE = 2'd3;
  // digits kept by the entry register, and where its count saturates
  localparam int ENTRY_DIGITS = kcl_pkg::CODE_DIGITS_DEF;
  localparam int COUNT_CAP = kcl_pkg::CODE_DIGITS_DEF + 1;
  localparam int PHASE_ITEMS = 225;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 150;
  localparam int SETTLE_CYCLES = 4;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic [1:0]  kind = kcl_pkg::KIND_KEY;
  logic [3:0]  key_code = 4'd0;
  logic        remote_grant = 1'b0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic [2:0]  event_res;
  logic        door_open;
  logic        alarm_on;
  logic [15:0] entered_code;
  logic [2:0]  entered_count;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = kcl_pkg::CFG_PASSCODE;
  logic [15:0] cfg_data = 16'd0;

  keypad_code_lock u_top (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // one row of the directed table: either a register write or an event,
  // the event optionally carrying a hand-written result
  typedef struct {
    bit                    is_reg;
    kcl_pkg::kcl_item_t    itm;
    kcl_pkg::kcl_cfg_idx_t idx;
    logic [15:0]           val;
    bit                    pinned;
    kcl_pkg::kcl_res_t     res;
  } step_row_t;

  // lock state as the bench sees it
  logic [15:0] code_reg, open_reg, half_reg;
  logic [3:0]  pulses_reg;
  logic [15:0] entry_bcd;
  logic [2:0]  entry_len;
  logic [15:0] relock_left;
  logic        door_st;
  logic [4:0]  alarm_left;
  logic [15:0] alarm_tmr;

  kcl_pkg::kcl_res_t  due_results[$];
  kcl_pkg::kcl_item_t key_plan[$];

  // hand-written result travelling alongside the current transfer
  logic               pin_has = 1'b0;
  kcl_pkg::kcl_res_t  pin_res = '0;

  int send_idle = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int faults = 0;
  int cycle_cnt = 0;
  int items_in = 0;
  int checked = 0;
  int ev_seen[8];

  kcl_pkg::kcl_res_t  mon_want, mon_got;

  // -------------------------------------------------------------------------
  // predictor
  // -------------------------------------------------------------------------

  function automatic void unlock_door();
    door_st = 1'b1;
    relock_left = open_reg;
  endfunction

  // each pulse is an on phase and an off phase
  function automatic void sound_alarm();
    alarm_left = {pulses_reg, 1'b0};
    alarm_tmr = half_reg;
  endfunction

  function automatic kcl_pkg::kcl_res_t lock_step(kcl_pkg::kcl_item_t it);
    kcl_pkg::kcl_res_t r;
    r = '0;
    r.event_res = kcl_pkg::EV_NONE;
    case (it.kind)
      kcl_pkg::KIND_KEY: begin
        // keypad is dead while the alarm runs
        if (alarm_left == 0) begin
          if (it.key_code <= kcl_pkg::KEY_DIGIT_MAX) begin
            entry_bcd = {entry_bcd[11:0], it.key_code};
            if (entry_len < COUNT_CAP) entry_len = entry_len + 3'd1;
            r.event_res = kcl_pkg::EV_DIGIT;
          end else if (it.key_code == kcl_pkg::KEY_STAR) begin
            entry_bcd = '0;
            entry_len = '0;
            r.event_res = kcl_pkg::EV_CLEAR;
          end else if (it.key_code == kcl_pkg::KEY_HASH) begin
            r.entered_code = entry_bcd;
            r.entered_count = entry_len;
            if (entry_len == ENTRY_DIGITS && entry_bcd == code_reg) begin
              unlock_door();
              r.event_res = kcl_pkg::EV_GRANT;
            end else begin
              sound_alarm();
              r.event_res = kcl_pkg::EV_DENY;
            end
            entry_bcd = '0;
            entry_len = '0;
          end
        end
      end
      kcl_pkg::KIND_TICK: begin
        // relock countdown and alarm timer run side by side
        if (door_st) begin
          if (relock_left <= 1) begin
            relock_left = '0;
            door_st = 1'b0;
            r.event_res = kcl_pkg::EV_RELOCK;
          end else begin
            relock_left = relock_left - 16'd1;
          end
        end
        if (alarm_left != 0) begin
          if (alarm_tmr <= 1) begin
            alarm_left = alarm_left - 5'd1;
            alarm_tmr = half_reg;
          end else begin
            alarm_tmr = alarm_tmr - 16'd1;
          end
        end
      end
      kcl_pkg::KIND_REMOTE: begin
        if (it.remote_grant) begin
          unlock_door();
          r.event_res = kcl_pkg::EV_GRANT;
        end else begin
          sound_alarm();
          r.event_res = kcl_pkg::EV_DENY;
        end
      end
      default: ;
    endcase
    r.door_open = door_st;
    r.alarm_on = (alarm_left != 0) && !alarm_left[0];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] seen);
    if (want !== seen) begin
      faults++;
      $display("%0t ns: %s mismatch, expected %0h got %0h", $time, name, want, seen);
    end
  endtask

  // -------------------------------------------------------------------------
  // monitor: register writes and item transfers feed the predictor, result
  // transfers are compared against the oldest outstanding expectation
  // -------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      code_reg    = kcl_pkg::PASSCODE_RST;
      open_reg    = kcl_pkg::OPEN_TICKS_RST;
      half_reg    = kcl_pkg::ALARM_HALF_RST;
      pulses_reg  = kcl_pkg::ALARM_PULS_RST;
      entry_bcd   = '0;
      entry_len   = '0;
      relock_left = '0;
      door_st     = 1'b0;
      alarm_left  = '0;
      alarm_tmr   = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          kcl_pkg::CFG_PASSCODE:   code_reg = cfg_data;
          kcl_pkg::CFG_OPEN_TICKS: open_reg = cfg_data;
          kcl_pkg::CFG_ALARM_HALF: half_reg = cfg_data;
          kcl_pkg::CFG_ALARM_PULS: pulses_reg = cfg_data[3:0];
          default: ;
        endcase
      end
      if (item_valid && !item_stall) begin
        mon_got = lock_step({kind, key_code, remote_grant});
        // a hand-written row still steps the predictor, but its own value wins
        due_results.push_back(pin_has ? pin_res : mon_got);
        items_in++;
      end
      if (res_valid && !res_stall) begin
        if (due_results.size() == 0) begin
          faults++;
          $display("%0t ns: result with nothing expected, event %0d", $time, event_res);
        end else begin
          mon_want = due_results.pop_front();
          check_field("event_res", mon_want.event_res, event_res);
          check_field("door_open", mon_want.door_open, door_open);
          check_field("alarm_on", mon_want.alarm_on, alarm_on);
          check_field("entered_code", mon_want.entered_code, entered_code);
          check_field("entered_count", mon_want.entered_count, entered_count);
          ev_seen[mon_want.event_res]++;
          checked++;
        end
      end
    end
  end

  // receiver: random stalls, or a long hold-off once one is requested
  always @(negedge clk) begin
    if (hold_left > 0) begin
      res_stall <= 1'b1;
      hold_left--;
    end else begin
      res_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timed out after %0d cycles, %0d results outstanding",
               cycle_cnt, due_results.size());
      $display("FAIL");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // sender side
  // -------------------------------------------------------------------------

  // called just after a rising edge; returns on a falling edge
  task automatic sender_gap();
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  // called on a falling edge; returns on the rising edge of the transfer
  task automatic offer(input kcl_pkg::kcl_item_t it, input bit has,
                       input kcl_pkg::kcl_res_t r);
    item_valid   <= 1'b1;
    kind         <= it.kind;
    key_code     <= it.key_code;
    remote_grant <= it.remote_grant;
    pin_has      <= has;
    pin_res      <= r;
    do @(posedge clk); while (item_stall);
  endtask

  // stop offering and let every outstanding result come back
  task automatic wait_drained();
    @(negedge clk);
    item_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input kcl_pkg::kcl_cfg_idx_t idx, input logic [15:0] val);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] rand_bcd();
    return {4'($urandom_range(9)), 4'($urandom_range(9)),
            4'($urandom_range(9)), 4'($urandom_range(9))};
  endfunction

  // refill the plan from the current lock state: mostly code attempts and
  // tick bursts, with remote decisions and raw noise mixed in
  function automatic void plan_burst();
    int r;
    int v;
    logic [15:0] code;
    r = $urandom_range(99);
    if (alarm_left != 0) begin
      // keys are dead now, so push time forward most of the time
      if (r < 70) begin
        repeat ($urandom_range(1, 6))
          key_plan.push_back({kcl_pkg::KIND_TICK, 4'($urandom_range(15)),
                              1'($urandom_range(1))});
      end else if (r < 85) begin
        key_plan.push_back({kcl_pkg::KIND_REMOTE, 4'($urandom_range(15)),
                            1'($urandom_range(1))});
      end else begin
        key_plan.push_back({kcl_pkg::KIND_KEY, 4'($urandom_range(15)),
                            1'($urandom_range(1))});
      end
    end else if (r < 45) begin
      if ($urandom_range(4) == 0)
        key_plan.push_back({kcl_pkg::KIND_KEY, kcl_pkg::KEY_STAR, 1'b0});
      v = $urandom_range(3);
      code = code_reg;
      // one digit redrawn at random
      if (v == 2) code[4 * $urandom_range(3) +: 4] = 4'($urandom_range(9));
      if (v == 3) begin
        // random length from one to seven digits: short, right or overlong
        repeat ($urandom_range(1, 7))
          key_plan.push_back({kcl_pkg::KIND_KEY, 4'($urandom_range(9)),
                              1'($urandom_range(1))});
      end else begin
        for (int i = ENTRY_DIGITS - 1; i >= 0; i--)
          key_plan.push_back({kcl_pkg::KIND_KEY, code[4 * i +: 4], 1'($urandom_range(1))});
      end
      key_plan.push_back({kcl_pkg::KIND_KEY, kcl_pkg::KEY_HASH, 1'b0});
    end else if (r < 75) begin
      repeat ($urandom_range(1, 8))
        key_plan.push_back({kcl_pkg::KIND_TICK, 4'($urandom_range(15)),
                            1'($urandom_range(1))});
    end else if (r < 85) begin
      key_plan.push_back({kcl_pkg::KIND_REMOTE, 4'($urandom_range(15)),
                          1'($urandom_range(1))});
    end else begin
      key_plan.push_back({2'($urandom_range(3)), 4'($urandom_range(15)),
                          1'($urandom_range(1))});
    end
  endfunction

  // -------------------------------------------------------------------------
  // directed table builders
  // -------------------------------------------------------------------------

  function automatic step_row_t ev_row(logic [1:0] k, logic [3:0] key, logic g);
    step_row_t r;
    r.is_reg = 1'b0;
    r.itm = {k, key, g};
    r.idx = kcl_pkg::CFG_PASSCODE;
    r.val = '0;
    r.pinned = 1'b0;
    r.res = '0;
    return r;
  endfunction

  function automatic step_row_t ev_pin(logic [1:0] k, logic [3:0] key, logic g,
                                       kcl_pkg::kcl_ev_t ev, logic dr, logic al,
                                       logic [15:0] code, logic [2:0] cnt);
    step_row_t r;
    r = ev_row(k, key, g);
    r.pinned = 1'b1;
    r.res = {ev, dr, al, code, cnt};
    return r;
  endfunction

  function automatic step_row_t reg_row(kcl_pkg::kcl_cfg_idx_t i, logic [15:0] v);
    step_row_t r;
    r = ev_row(kcl_pkg::KIND_KEY, 4'd0, 1'b0);
    r.is_reg = 1'b1;
    r.idx = i;
    r.val = v;
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // main sequence
  // -------------------------------------------------------------------------

  initial begin
    step_row_t steps[$];
    kcl_pkg::kcl_item_t nxt;
    int live;
    bit mid_done;

    // ---- directed table, starting from the reset settings (code 7890)
    steps.push_back(ev_pin(kcl_pkg::KIND_TICK, 4'd0, 1'b0,
                           kcl_pkg::EV_NONE, 0, 0, 16'h0, 0));
    steps.push_back(ev_pin(kcl_pkg::KIND_KEY, 4'd7, 1'b0,
                           kcl_pkg::EV_DIGIT, 0, 0, 16'h0, 0));
    steps.push_back(ev_pin(kcl_pkg::KIND_KEY, 4'd8, 1'b0,
                           kcl_pkg::EV_DIGIT, 0, 0, 16'h0, 0));
    steps.push_back(ev_pin(kcl_pkg::KIND_KEY, 4'd9, 1'b0,
                           kcl_pkg::EV_DIGIT, 0, 0, 16'h0, 0));
    steps.push_back(ev_pin(kcl_pkg::KIND_KEY, 4'd0, 1'b0,
                           kcl_pkg::EV_DIGIT, 0, 0, 16'h0, 0));
    steps.push_back(ev_pin(kcl_pkg::KIND_KEY, kcl_pkg::KEY_HASH, 1'b0,
                           kcl_pkg::EV_GRANT, 1, 0, 16'h7890, 4));
    steps.push_back(ev_pin(kcl_pkg::KIND_TICK, 4'd0, 1'b0,
                           kcl_pkg::EV_NONE, 1, 0, 16'h0, 0));
    // unused key code and unused kind are both dropped
    steps.push_back(ev_pin(kcl_pkg::KIND_KEY, 4'd15, 1'b1,
                           kcl_pkg::EV_NONE, 1, 0, 16'h0, 0));
    steps.push_back(ev_pin(KIND_SPARE, kcl_pkg::KEY_HASH, 1'b1,
                           kcl_pkg::EV_NONE, 1, 0, 16'h0, 0));
    steps.push_back(ev_pin(kcl_pkg::KIND_KEY, kcl_pkg::KEY_STAR, 1'b0,
                           kcl_pkg::EV_CLEAR, 1, 0, 16'h0, 0));
    // a one-digit entry is refused and the alarm starts
    steps.push_back(ev_pin(kcl_pkg::KIND_KEY, 4'd3, 1'b0,
                           kcl_pkg::EV_DIGIT, 1, 0, 16'h0, 0));
    steps.push_back(ev_pin(kcl_pkg::KIND_KEY, kcl_pkg::KEY_HASH, 1'b0,
                           kcl_pkg::EV_DENY, 1, 1, 16'h0003, 1));
    // keys are ignored while the alarm runs, remote decisions are not
    steps.push_back(ev_pin(kcl_pkg::KIND_KEY, 4'd5, 1'b0,
                           kcl_pkg::EV_NONE, 1, 1, 16'h0, 0));
    steps.push_back(ev_pin(kcl_pkg::KIND_REMOTE, 4'd0, 1'b1,
                           kcl_pkg::EV_GRANT, 1, 1, 16'h0, 0));
    // zero pulses: a remote deny is reported but silences the alarm
    steps.push_back(reg_row(kcl_pkg::CFG_ALARM_PULS, 16'd0));
    steps.push_back(ev_pin(kcl_pkg::KIND_REMOTE, 4'd0, 1'b0,
                           kcl_pkg::EV_DENY, 1, 0, 16'h0, 0));
    // open time of one: a single tick relocks
    steps.push_back(reg_row(kcl_pkg::CFG_OPEN_TICKS, 16'd1));
    steps.push_back(ev_pin(kcl_pkg::KIND_REMOTE, 4'd0, 1'b1,
                           kcl_pkg::EV_GRANT, 1, 0, 16'h0, 0));
    steps.push_back(ev_pin(kcl_pkg::KIND_TICK, 4'd0, 1'b0,
                           kcl_pkg::EV_RELOCK, 0, 0, 16'h0, 0));
    // all-zero code, zero open time, widest alarm
    steps.push_back(reg_row(kcl_pkg::CFG_PASSCODE, 16'h0000));
    steps.push_back(reg_row(kcl_pkg::CFG_OPEN_TICKS, 16'd0));
    steps.push_back(reg_row(kcl_pkg::CFG_ALARM_PULS, 16'd15));
    steps.push_back(reg_row(kcl_pkg::CFG_ALARM_HALF, 16'hffff));
    repeat (ENTRY_DIGITS)
      steps.push_back(ev_pin(kcl_pkg::KIND_KEY, 4'd0, 1'b0,
                             kcl_pkg::EV_DIGIT, 0, 0, 16'h0, 0));
    steps.push_back(ev_pin(kcl_pkg::KIND_KEY, kcl_pkg::KEY_HASH, 1'b0,
                           kcl_pkg::EV_GRANT, 1, 0, 16'h0000, 4));
    steps.push_back(ev_pin(kcl_pkg::KIND_TICK, 4'd0, 1'b0,
                           kcl_pkg::EV_RELOCK, 0, 0, 16'h0, 0));
    // a code that no keypad entry can match, checked with an empty entry
    steps.push_back(reg_row(kcl_pkg::CFG_PASSCODE, 16'hffff));
    steps.push_back(ev_pin(kcl_pkg::KIND_KEY, kcl_pkg::KEY_HASH, 1'b0,
                           kcl_pkg::EV_DENY, 0, 1, 16'h0, 0));
    steps.push_back(ev_row(kcl_pkg::KIND_TICK, 4'd0, 1'b0));
    // zero half period behaves as one tick per phase
    steps.push_back(reg_row(kcl_pkg::CFG_ALARM_PULS, 16'd1));
    steps.push_back(reg_row(kcl_pkg::CFG_ALARM_HALF, 16'd0));
    steps.push_back(ev_row(kcl_pkg::KIND_REMOTE, 4'd0, 1'b0));
    steps.push_back(ev_row(kcl_pkg::KIND_TICK, 4'd0, 1'b0));
    steps.push_back(ev_row(kcl_pkg::KIND_TICK, 4'd0, 1'b0));

    // ---- reset
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (steps[i]) begin
      if (steps[i].is_reg) begin
        write_reg(steps[i].idx, steps[i].val);
      end else begin
        sender_gap();
        offer(steps[i].itm, steps[i].pinned, steps[i].res);
      end
    end

    // ---- random phases, each with its own settings and pacing
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(kcl_pkg::CFG_PASSCODE, rand_bcd());
          write_reg(kcl_pkg::CFG_OPEN_TICKS, 16'($urandom_range(1, 12)));
          write_reg(kcl_pkg::CFG_ALARM_HALF, 16'd1);
          write_reg(kcl_pkg::CFG_ALARM_PULS, 16'd1);
          send_idle = 0;
          stall_pct = 0;
        end
        1: begin
          write_reg(kcl_pkg::CFG_PASSCODE, 16'h9999);
          write_reg(kcl_pkg::CFG_OPEN_TICKS, 16'($urandom_range(1, 40)));
          write_reg(kcl_pkg::CFG_ALARM_HALF, 16'($urandom_range(1, 4)));
          write_reg(kcl_pkg::CFG_ALARM_PULS, 16'($urandom_range(1, 3)));
          send_idle = 70;
          stall_pct = 0;
        end
        2: begin
          write_reg(kcl_pkg::CFG_PASSCODE, rand_bcd());
          write_reg(kcl_pkg::CFG_OPEN_TICKS, 16'($urandom_range(1, 40)));
          write_reg(kcl_pkg::CFG_ALARM_HALF, 16'($urandom_range(1, 4)));
          write_reg(kcl_pkg::CFG_ALARM_PULS, 16'd2);
          send_idle = 0;
          stall_pct = 70;
        end
        default: begin
          write_reg(kcl_pkg::CFG_PASSCODE, rand_bcd());
          write_reg(kcl_pkg::CFG_OPEN_TICKS, 16'($urandom_range(1, 40)));
          write_reg(kcl_pkg::CFG_ALARM_HALF, 16'd1);
          write_reg(kcl_pkg::CFG_ALARM_PULS, 16'd15);
          send_idle = 24;
          stall_pct = 24;
        end
      endcase
      key_plan.delete();
      live = 0;
      mid_done = 1'b0;
      while (live < PHASE_ITEMS) begin
        sender_gap();
        if (key_plan.size() == 0) plan_burst();
        nxt = key_plan.pop_front();
        // dropped items do not count towards the phase length
        if (!(nxt.kind == KIND_SPARE ||
              (nxt.kind == kcl_pkg::KIND_KEY &&
               (nxt.key_code > kcl_pkg::KEY_HASH || alarm_left != 0))))
          live++;
        offer(nxt, 1'b0, '0);
        if (live >= PHASE_ITEMS / 2 && !mid_done) begin
          mid_done = 1'b1;
          // back-pressure: receiver holds off while the sender keeps pushing
          if (ph == 0) hold_left = HOLD_CYCLES;
          // sender pauses until the pipe has emptied
          if (ph == 1) wait_drained();
        end
      end
    end

    wait_drained();

    $display("ran %0d items through directed rows and four pacing phases, %0d results compared",
             items_in, checked);
    $display("grants %0d, denials %0d, relocks %0d, digits %0d, clears %0d, quiet %0d",
             ev_seen[kcl_pkg::EV_GRANT], ev_seen[kcl_pkg::EV_DENY],
             ev_seen[kcl_pkg::EV_RELOCK], ev_seen[kcl_pkg::EV_DIGIT],
             ev_seen[kcl_pkg::EV_CLEAR], ev_seen[kcl_pkg::EV_NONE]);
    if (faults == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/kcl_pkg.sv
src/kcl_cfg.sv
src/kcl_ctrl.sv
src/keypad_code_lock.sv
src/kcl_chk.sv
verif/keypad_code_lock_test.sv
